/* sv/sckp_pkg.sv */
// Shared constants for the cubic spline kernel pair pipeline.
package sckp_pkg;

	localparam int unsigned SQ_STAGES = 16;
	localparam int unsigned POLY_STAGES = 8;
	localparam int unsigned LATENCY = 3 + SQ_STAGES + POLY_STAGES;

	localparam logic [31:0] DIST_FLOOR = 32'd4;
	localparam logic [30:0] H_ONE = 31'h4000_0000;
	localparam logic [32:0] BEYOND_LIMIT = 33'd7516192768;
	localparam logic [28:0] DIV_Q16 = 29'd486548242;
	localparam logic [30:0] GRAD_Q8 = 31'd1551493120;
	// ceil(2^35/7); exact floor(x/7) for x < 2^33
	localparam logic [32:0] RECIP7 = 33'd4908534053;
	localparam int unsigned RECIP7_SHIFT = 35;

endpackage

/* sv/sckp_sqrt.sv */
// Pipelined integer square root, two result bits per stage.
module sckp_sqrt import sckp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_sum,
	output logic        out_valid,
	output logic [31:0] out_root
);

	typedef struct packed {
		logic [63:0] n;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		sq_t res;
		logic [35:0] r;
		logic [35:0] t;
		r = {a.rem, a.n[63:62]};
		t = {2'b00, a.root, 2'b01};
		res.n = {a.n[61:0], 2'b00};
		if (r >= t) begin
			res.rem = 34'(r - t);
			res.root = {a.root[30:0], 1'b1};
		end else begin
			res.rem = r[33:0];
			res.root = {a.root[30:0], 1'b0};
		end
		return res;
	endfunction

	logic valid_s [0:SQ_STAGES];
	sq_t  data_s  [0:SQ_STAGES];

	always_comb begin
		valid_s[0] = in_valid;
		data_s[0] = '{n: in_sum, rem: '0, root: '0};
	end

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			data_s[g+1] <= sq_step(sq_step(data_s[g]));
		end
	end

	assign out_valid = valid_s[SQ_STAGES];
	assign out_root = data_s[SQ_STAGES].root;

endmodule

/* sv/sckp_poly.sv */
// Distance to h, kernel polynomial and gradient scalar, eight stages.
module sckp_poly import sckp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] in_dist,
	output logic        out_valid,
	output logic [31:0] out_kernel,
	output logic [33:0] out_grad,
	output logic        out_beyond
);

	logic [7:0]  valid_s;
	logic [32:0] x_s1;
	logic        beyond_s1, beyond_s2, beyond_s3, beyond_s4, beyond_s5, beyond_s6, beyond_s7;
	logic [65:0] q_s2;
	logic [30:0] h_s3, h_s4;
	logic [61:0] hh_s4;
	logic [31:0] num_s4;
	logic [30:0] h2_s5;
	logic [60:0] h2h_s5;
	logic [62:0] gprod_s5;
	logic [30:0] p_s6;
	logic [32:0] gmag_s6, gmag_s7;
	logic [59:0] kprod_s7;
	logic [31:0] kern_s8;
	logic [33:0] grad_s8;
	logic        beyond_s8;

	logic [31:0] dist_f;
	logic [37:0] x_full;
	logic [33:0] nine_h;
	logic [30:0] h3;
	logic [32:0] p_wide;
	logic [63:0] gsum;
	logic [60:0] ksum;

	always_comb begin
		dist_f = (in_dist < DIST_FLOOR) ? DIST_FLOOR : in_dist;
		x_full = {1'b0, dist_f, 5'b0} + {2'b0, dist_f, 4'b0} + {5'b0, dist_f, 1'b0};
		nine_h = {h_s3, 3'b0} + {3'b0, h_s3};
		h3 = 31'(h2h_s5 >> 30);
		p_wide = {2'b0, H_ONE} + {2'b0, 31'((34'(h3) * 34'd3) >> 2)}
			- 33'((34'(h2_s5) * 34'd3) >> 1);
		gsum = {1'b0, gprod_s5} + 64'h2000_0000;
		ksum = {1'b0, kprod_s7} + 61'h2000_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// s1: floor, scale by 50, range test
		beyond_s1 <= x_full > {5'b0, BEYOND_LIMIT};
		x_s1 <= x_full[32:0];
		// s2: divide by 7 through reciprocal
		q_s2 <= x_s1 * RECIP7;
		beyond_s2 <= beyond_s1;
		// s3: h, clamped beyond range
		h_s3 <= beyond_s2 ? H_ONE : 31'(q_s2 >> RECIP7_SHIFT);
		beyond_s3 <= beyond_s2;
		// s4
		hh_s4 <= h_s3 * h_s3;
		num_s4 <= 32'({H_ONE, 1'b0} + {1'b0, H_ONE}) - 32'(nine_h >> 2);
		h_s4 <= h_s3;
		beyond_s4 <= beyond_s3;
		// s5
		h2_s5 <= 31'(hh_s4 >> 30);
		h2h_s5 <= 31'(hh_s4 >> 30) * h_s4;
		gprod_s5 <= num_s4 * GRAD_Q8;
		beyond_s5 <= beyond_s4;
		// s6
		p_s6 <= p_wide[30:0];
		gmag_s6 <= 33'(gsum >> 30);
		beyond_s6 <= beyond_s5;
		// s7
		kprod_s7 <= p_s6 * DIV_Q16;
		gmag_s7 <= gmag_s6;
		beyond_s7 <= beyond_s6;
		// s8
		kern_s8 <= 32'(ksum >> 30);
		grad_s8 <= 34'd0 - {1'b0, gmag_s7};
		beyond_s8 <= beyond_s7;
	end

	assign out_valid = valid_s[7];
	assign out_kernel = kern_s8;
	assign out_grad = grad_s8;
	assign out_beyond = beyond_s8;

endmodule

/* sv/sph_cubic_kernel_pair_core.sv */
// Top level: cubic spline kernel and gradient scalar for one particle pair.
//
// channel   direction  transfer                  payload
// command   in         start & !busy at clk edge delta_x, delta_y, delta_z
// result    out        done, one cycle           kernel_value, gradient_scalar, beyond_range
//
// One pair enters per cycle; busy stays low.
// The time from transfer to done is set mostly by the 16-stage square root.
// Reset clears only the valid bits; payload registers run free.
// The receiver cannot stall, so the pipeline never holds.
module sph_cubic_kernel_pair_core import sckp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	output logic               done,
	output logic        [31:0] kernel_value,
	output logic signed [33:0] gradient_scalar,
	output logic               beyond_range
);

	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] ax_s1, ay_s1, az_s1;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [63:0] sum_s3;
	logic        root_valid;
	logic [31:0] root;
	logic [33:0] grad;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'(33'h1_0000_0000 - {1'b0, v}) : v;
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= mag32(delta_x);
		ay_s1 <= mag32(delta_y);
		az_s1 <= mag32(delta_z);
		sx_s2 <= ax_s1 * ax_s1;
		sy_s2 <= ay_s1 * ay_s1;
		sz_s2 <= az_s1 * az_s1;
		sum_s3 <= sx_s2 + sy_s2 + sz_s2;
	end

	sckp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_sum   (sum_s3),
		.out_valid(root_valid),
		.out_root (root)
	);

	sckp_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_valid),
		.in_dist   (root),
		.out_valid (done),
		.out_kernel(kernel_value),
		.out_grad  (grad),
		.out_beyond(beyond_range)
	);

	assign gradient_scalar = signed'(grad);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##27 done) else $error("result missing after fixed latency");
	a_grad_neg: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> gradient_scalar[33]) else $error("gradient scalar not negative");
	a_kern_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> kernel_value <= 32'(DIV_Q16)) else $error("kernel above h=0 value");

endmodule

/* sim/sckp_checker.sv */
// Result checker for the cubic spline kernel pair core: predicts and compares.
`timescale 1ns / 100ps
module sckp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	input  logic               done,
	input  logic        [31:0] kernel_value,
	input  logic signed [33:0] gradient_scalar,
	input  logic               beyond_range,
	output int                 fail_count,
	output int                 pending_count
);
	import sckp_pkg::*;

	typedef struct packed {
		logic [31:0] kern;
		logic [33:0] grad;
		logic        beyond;
	} kernel_result_t;

	kernel_result_t pending_results[$];

	function automatic logic [63:0] abs32(logic signed [31:0] v);
		logic [63:0] w;
		w = {{32{v[31]}}, v};
		return v[31] ? 64'd0 - w : w;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] n);
		logic [63:0] op, res, bitv;
		op = n;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > op)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (op >= res + bitv) begin
				op = op - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic kernel_result_t kernel_of_pair(logic signed [31:0] dx,
			logic signed [31:0] dy, logic signed [31:0] dz);
		logic [63:0] ax, ay, az, distance, h, h2, h3, p, num, gmag;
		logic [127:0] wide;
		kernel_result_t r;
		ax = abs32(dx);
		ay = abs32(dy);
		az = abs32(dz);
		distance = root64(ax * ax + ay * ay + az * az);
		if (distance < 64'(DIST_FLOOR))
			distance = 64'(DIST_FLOOR);
		r.beyond = distance * 50 > 64'(BEYOND_LIMIT);
		h = r.beyond ? 64'(H_ONE) : (distance * 50) / 7;
		h2 = (h * h) >> 30;
		h3 = (h2 * h) >> 30;
		p = 64'(H_ONE) - ((3 * h2) >> 1) + ((3 * h3) >> 2);
		wide = (128'(p) * 128'(DIV_Q16) + (128'd1 << 29)) >> 30;
		r.kern = wide[31:0];
		num = 3 * 64'(H_ONE) - ((9 * h) >> 2);
		wide = (128'(num) * 128'(GRAD_Q8) + (128'd1 << 29)) >> 30;
		gmag = wide[63:0];
		r.grad = 34'(64'd0 - gmag);
		return r;
	endfunction

	kernel_result_t want;
	int             errs;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			pending_results.delete();
		end else begin
			errs = 0;
			if (start && !busy)
				pending_results.push_back(kernel_of_pair(delta_x, delta_y, delta_z));
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer");
					errs = errs + 1;
				end else begin
					want = pending_results.pop_front();
					if (kernel_value !== want.kern) begin
						$error("kernel_value exp %0d got %0d", want.kern, kernel_value);
						errs = errs + 1;
					end
					if (gradient_scalar !== want.grad) begin
						$error("gradient_scalar exp %0d got %0d", $signed(want.grad),
							gradient_scalar);
						errs = errs + 1;
					end
					if (beyond_range !== want.beyond) begin
						$error("beyond_range exp %0d got %0d", want.beyond, beyond_range);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

	assign pending_count = pending_results.size();

endmodule

/* sim/tb_top.sv */
// Testbench top for the cubic spline kernel pair core: stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
	import sckp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] delta_x = '0;
	logic signed [31:0] delta_y = '0;
	logic signed [31:0] delta_z = '0;
	logic               done;
	logic        [31:0] kernel_value;
	logic signed [33:0] gradient_scalar;
	logic               beyond_range;
	int                 fail_count;
	int                 pending_count;
	int                 idle_cycles = 0;

	localparam int N_RANDOM = 1300;
	localparam int STALL_LIMIT = 200 + 4 * LATENCY;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sph_cubic_kernel_pair_core DUT (.*);

	sckp_checker u_checker (.*);

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_pair(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		start <= 1'b1;
		delta_x <= x;
		delta_y <= y;
		delta_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// mostly in-range distances (|d| < ~0.035 m), some far and some tiny
	function automatic logic signed [31:0] rand_component(int mode);
		case (mode)
			0: return $signed(32'($urandom_range(0, 20)) - 32'd10);
			1: return $signed($urandom);
			default: return $signed(32'($urandom_range(0, 200000000)) - 32'd100000000);
		endcase
	endfunction

	initial begin
		int mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero, tiny, edge of range, extremes
		send_pair(0, 0, 0);
		send_pair(1, 0, 0);
		send_pair(3, 1, -1);
		send_pair(-4, 0, 0);
		send_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_pair(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_pair(32'sh80000000, 0, 32'sh7fffffff);
		send_pair(150323855, 0, 0);
		send_pair(150323856, 0, 0);
		send_pair(0, -150323855, 0);
		send_pair(0, 0, -150323857);
		send_pair(86787858, 86787858, 86787858);
		send_pair(-75161927, 0, 0);
		send_pair(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i < N_RANDOM - 200 && $urandom_range(0, 15) == 0)
				pause_sender($urandom_range(1, 19));
			mode = $urandom_range(0, 9);
			mode = (mode == 0) ? 0 : (mode < 3) ? 1 : 2;
			send_pair(rand_component(mode), rand_component(mode), rand_component(mode));
		end
		start <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
